// ===== hw/rtl/msc_pkg.sv =====
// Shared types, codes and helpers of the MESI snooping cache controller.
package msc_pkg;

  localparam logic [31:0] STAMP_LIMIT = 32'h7fff_ffff;
  localparam int unsigned TAG_BITS = 30;
  localparam int unsigned SET_MAX_BITS = 12;
  localparam logic [2:0] MAX_EVENTS = 3'd7;

  typedef enum logic [1:0] {
    COH_I = 2'd0,
    COH_S = 2'd1,
    COH_E = 2'd2,
    COH_M = 2'd3
  } coh_e;

  typedef enum logic [2:0] {
    EV_PRRD    = 3'd0,
    EV_PRWR    = 3'd1,
    EV_BUSRD   = 3'd2,
    EV_BUSRDX  = 3'd3,
    EV_FLUSH   = 3'd4,
    EV_BUSWB   = 3'd5,
    EV_REPLACE = 3'd6
  } evk_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_BUS,
    ST_SNRD,
    ST_SNDATA,
    ST_SNWB,
    ST_REPL,
    ST_VWB,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  core_id;
    logic        opcode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        on_bus;
    logic [1:0]  actor_core;
    logic [31:0] event_address;
    logic        last_event;
  } evt_t;

  typedef struct packed {
    logic [1:0]              core;
    logic                    write;
    logic [31:0]             address;
    logic [TAG_BITS-1:0]     tag;
    logic [SET_MAX_BITS-1:0] set;
  } cmd_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    coh_e                coh;
    logic [31:0]         stamp;
  } line_t;

  function automatic evt_t mk_evt(evk_e kind, logic bus, logic [1:0] actor,
                                  logic [31:0] addr);
    evt_t e;
    e.event_kind    = kind;
    e.on_bus        = bus;
    e.actor_core    = bus ? 2'd0 : actor;
    e.event_address = addr;
    e.last_event    = 1'b0;
    return e;
  endfunction

endpackage

// ===== hw/rtl/msc_fifo.sv =====
// Two-entry queue used between the front and back parts and on the event output.
module msc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hw/rtl/msc_front.sv =====
// Front part: accepts requests, drops unknown cores, splits the address into set and tag.
module msc_front #(
  parameter int unsigned CORE_COUNT     = 4,
  parameter int unsigned SET_INDEX_BITS = 6
) (
  input  logic               in_valid_i,
  input  msc_pkg::req_t      in_req_i,
  input  logic [4:0]         offset_i,
  input  logic               q_ready_i,
  output logic               in_ready_o,
  output logic               q_push_o,
  output msc_pkg::cmd_t      q_cmd_o
);

  logic [5:0] sh;
  logic       in_range;

  assign in_ready_o = q_ready_i;
  assign in_range   = ({3'b000, in_req_i.core_id} < 5'(CORE_COUNT));
  assign q_push_o   = in_valid_i && in_range;

  always_comb begin
    sh = 6'(SET_INDEX_BITS) + {1'b0, offset_i};
    q_cmd_o.core    = in_req_i.core_id;
    q_cmd_o.write   = in_req_i.opcode;
    q_cmd_o.address = in_req_i.address;
    q_cmd_o.set     = msc_pkg::SET_MAX_BITS'(in_req_i.address >> offset_i)
                      & msc_pkg::SET_MAX_BITS'((1 << SET_INDEX_BITS) - 1);
    q_cmd_o.tag     = (sh >= 6'd32) ? '0 : msc_pkg::TAG_BITS'(in_req_i.address >> sh);
  end

endmodule

// ===== hw/rtl/msc_back.sv =====
// Back part: line store, lookup, snoop sweep over the other cores, fill and event sequencing.
module msc_back #(
  parameter int unsigned CORE_COUNT     = 4,
  parameter int unsigned SET_INDEX_BITS = 6,
  parameter int unsigned WAY_COUNT      = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [4:0]    offset_i,
  input  logic          q_valid_i,
  input  msc_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  input  logic          ev_ready_i,
  output logic          ev_push_o,
  output msc_pkg::evt_t ev_o
);

  localparam int unsigned CW   = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int unsigned RW   = CW + SET_INDEX_BITS;
  localparam int unsigned ROWS = CORE_COUNT << SET_INDEX_BITS;
  localparam int unsigned WW   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned NW   = $clog2(WAY_COUNT + 1);

  msc_pkg::line_t mem [ROWS][WAY_COUNT];
  msc_pkg::line_t rdata_q [WAY_COUNT];
  msc_pkg::line_t own_q [WAY_COUNT], own_d [WAY_COUNT];
  msc_pkg::line_t wdata [WAY_COUNT];
  logic           rd_en, wr_en;
  logic [RW-1:0]  raddr, waddr;

  msc_pkg::state_e state_q, state_d;
  msc_pkg::cmd_t   item_q, item_d;
  logic            hit_q, hit_d, vneed_q, vneed_d, copy_q, copy_d;
  logic [WW-1:0]   hway_q, hway_d, vway_q, vway_d;
  logic [CW:0]     c_q, c_d;
  logic [NW-1:0]   wbcnt_q, wbcnt_d;
  logic [2:0]      evcnt_q, evcnt_d;
  msc_pkg::evt_t   pend_q, pend_d, emit_evt;
  logic            pend_v_q, pend_v_d, emit, stall;
  logic [31:0]     stamp_q, stamp_d, nst;
  logic [RW-1:0]   clr_q, clr_d;
  logic [SET_INDEX_BITS-1:0] set;
  logic [CW:0]     my_core;

  // LOOK classification
  logic          l_hit, l_inv;
  logic [WW-1:0] l_hway, l_iway, l_mway;
  logic [31:0]   l_best;
  // SNDATA update
  logic          s_any;
  logic [NW-1:0] s_cnt;

  function automatic logic [RW-1:0] ridx(logic [CW:0] c, logic [SET_INDEX_BITS-1:0] s);
    return {c[CW-1:0], s};
  endfunction

  function automatic logic [31:0] blk_addr(logic [msc_pkg::TAG_BITS-1:0] tag,
                                           logic [SET_INDEX_BITS-1:0] s, logic [4:0] bo);
    logic [63:0] a;
    logic [5:0]  sh;
    sh = 6'(SET_INDEX_BITS) + {1'b0, bo};
    a  = (64'(tag) << sh) | (64'(s) << bo);
    return a[31:0];
  endfunction

  assign set     = item_q.set[SET_INDEX_BITS-1:0];
  assign my_core = (CW+1)'(item_q.core);
  assign nst     = (stamp_q < msc_pkg::STAMP_LIMIT) ? stamp_q + 32'd1 : stamp_q;

  // store: one row per core and set, all ways side by side
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int w = 0; w < WAY_COUNT; w++) mem[waddr][w] <= wdata[w];
    end
    if (rd_en) begin
      for (int w = 0; w < WAY_COUNT; w++) rdata_q[w] <= mem[raddr][w];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAY_COUNT; w++) own_q[w] <= own_d[w];
    item_q  <= item_d;
    hway_q  <= hway_d;
    vway_q  <= vway_d;
    pend_q  <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= msc_pkg::ST_CLEAR;
      hit_q    <= 1'b0;
      vneed_q  <= 1'b0;
      copy_q   <= 1'b0;
      c_q      <= '0;
      wbcnt_q  <= '0;
      evcnt_q  <= '0;
      pend_v_q <= 1'b0;
      stamp_q  <= '0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      hit_q    <= hit_d;
      vneed_q  <= vneed_d;
      copy_q   <= copy_d;
      c_q      <= c_d;
      wbcnt_q  <= wbcnt_d;
      evcnt_q  <= evcnt_d;
      pend_v_q <= pend_v_d;
      stamp_q  <= stamp_d;
      clr_q    <= clr_d;
    end
  end

  // lookup on the requester's row
  always_comb begin
    l_hit  = 1'b0;
    l_inv  = 1'b0;
    l_hway = '0;
    l_iway = '0;
    l_mway = '0;
    l_best = msc_pkg::STAMP_LIMIT;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!l_hit && rdata_q[w].coh != msc_pkg::COH_I && rdata_q[w].tag == item_q.tag) begin
        l_hit  = 1'b1;
        l_hway = WW'(w);
      end
      if (!l_inv && rdata_q[w].coh == msc_pkg::COH_I) begin
        l_inv  = 1'b1;
        l_iway = WW'(w);
      end
      if (rdata_q[w].stamp < l_best) begin
        l_best = rdata_q[w].stamp;
        l_mway = WW'(w);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    own_d    = own_q;
    hit_d    = hit_q;
    hway_d   = hway_q;
    vway_d   = vway_q;
    vneed_d  = vneed_q;
    copy_d   = copy_q;
    c_d      = c_q;
    wbcnt_d  = wbcnt_q;
    evcnt_d  = evcnt_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    stamp_d  = stamp_q;
    clr_d    = clr_q;
    rd_en    = 1'b0;
    raddr    = ridx(my_core, set);
    wr_en    = 1'b0;
    waddr    = ridx(my_core, set);
    wdata    = own_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    emit_evt = msc_pkg::mk_evt(msc_pkg::EV_PRRD, 1'b0, 2'd0, 32'd0);
    ev_push_o = 1'b0;
    ev_o     = pend_q;
    s_any    = 1'b0;
    s_cnt    = '0;

    case (state_q)
      msc_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        waddr = clr_q;
        for (int w = 0; w < WAY_COUNT; w++) wdata[w] = '0;
      end
      msc_pkg::ST_LOOK: begin
        emit     = 1'b1;
        emit_evt = msc_pkg::mk_evt(item_q.write ? msc_pkg::EV_PRWR : msc_pkg::EV_PRRD,
                                   1'b0, item_q.core, item_q.address);
      end
      msc_pkg::ST_BUS: begin
        emit     = 1'b1;
        emit_evt = msc_pkg::mk_evt(hit_q ? msc_pkg::EV_FLUSH :
                                   (item_q.write ? msc_pkg::EV_BUSRDX : msc_pkg::EV_BUSRD),
                                   1'b1, 2'd0, item_q.address);
      end
      msc_pkg::ST_SNDATA: begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          wdata[w] = rdata_q[w];
          if (rdata_q[w].coh != msc_pkg::COH_I && rdata_q[w].tag == item_q.tag) begin
            s_any = 1'b1;
            if (rdata_q[w].coh == msc_pkg::COH_M) s_cnt = s_cnt + NW'(1);
            if (item_q.write) wdata[w].coh = msc_pkg::COH_I;
            else wdata[w].coh = msc_pkg::COH_S;
          end
        end
        wr_en = 1'b1;
        waddr = ridx(c_q, set);
      end
      msc_pkg::ST_SNWB: begin
        emit     = 1'b1;
        emit_evt = msc_pkg::mk_evt(msc_pkg::EV_BUSWB, 1'b1, 2'd0,
                                   blk_addr(item_q.tag, set, offset_i));
      end
      msc_pkg::ST_REPL: begin
        emit     = 1'b1;
        emit_evt = msc_pkg::mk_evt(msc_pkg::EV_REPLACE, 1'b0, item_q.core,
                                   blk_addr(own_q[vway_q].tag, set, offset_i));
      end
      msc_pkg::ST_VWB: begin
        emit     = 1'b1;
        emit_evt = msc_pkg::mk_evt(msc_pkg::EV_BUSWB, 1'b1, 2'd0,
                                   blk_addr(own_q[vway_q].tag, set, offset_i));
      end
      msc_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (hit_q) begin
          if (item_q.write) wdata[hway_q].coh = msc_pkg::COH_M;
          wdata[hway_q].stamp = nst;
        end else begin
          wdata[vway_q].tag   = item_q.tag;
          wdata[vway_q].coh   = item_q.write ? msc_pkg::COH_M :
                                (copy_q ? msc_pkg::COH_S : msc_pkg::COH_E);
          wdata[vway_q].stamp = nst;
        end
      end
      msc_pkg::ST_DONE: begin
        ev_push_o = 1'b1;
        ev_o.last_event = 1'b1;
      end
      default: ;
    endcase

    // an event goes out once the next one (or the end) is known, so last can be set
    if (emit && evcnt_q < msc_pkg::MAX_EVENTS && pend_v_q) ev_push_o = 1'b1;
    stall = ev_push_o && !ev_ready_i;
    if (stall) begin
      wr_en = 1'b0;
    end else begin
      if (emit && evcnt_q < msc_pkg::MAX_EVENTS) begin
        pend_d   = emit_evt;
        pend_v_d = 1'b1;
        evcnt_d  = evcnt_q + 3'd1;
      end
      case (state_q)
        msc_pkg::ST_CLEAR: begin
          clr_d = clr_q + RW'(1);
          if (clr_q == RW'(ROWS - 1)) state_d = msc_pkg::ST_IDLE;
        end
        msc_pkg::ST_IDLE: begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            item_d  = q_cmd_i;
            rd_en   = 1'b1;
            raddr   = ridx((CW+1)'(q_cmd_i.core), q_cmd_i.set[SET_INDEX_BITS-1:0]);
            state_d = msc_pkg::ST_LOOK;
          end
        end
        msc_pkg::ST_LOOK: begin
          for (int w = 0; w < WAY_COUNT; w++) own_d[w] = rdata_q[w];
          hit_d   = l_hit;
          hway_d  = l_hway;
          vway_d  = l_inv ? l_iway : l_mway;
          vneed_d = !l_inv;
          if (l_hit && !(item_q.write && rdata_q[l_hway].coh == msc_pkg::COH_S)) begin
            state_d = msc_pkg::ST_WRITE;
          end else begin
            state_d = msc_pkg::ST_BUS;
          end
        end
        msc_pkg::ST_BUS: begin
          c_d     = '0;
          copy_d  = 1'b0;
          state_d = msc_pkg::ST_SNRD;
        end
        msc_pkg::ST_SNRD: begin
          if (c_q == (CW+1)'(CORE_COUNT)) begin
            state_d = (!hit_q && vneed_q) ? msc_pkg::ST_REPL : msc_pkg::ST_WRITE;
          end else if (c_q == my_core) begin
            c_d = c_q + (CW+1)'(1);
          end else begin
            rd_en   = 1'b1;
            raddr   = ridx(c_q, set);
            state_d = msc_pkg::ST_SNDATA;
          end
        end
        msc_pkg::ST_SNDATA: begin
          copy_d  = copy_q | s_any;
          wbcnt_d = s_cnt;
          c_d     = c_q + (CW+1)'(1);
          state_d = (s_cnt != '0) ? msc_pkg::ST_SNWB : msc_pkg::ST_SNRD;
        end
        msc_pkg::ST_SNWB: begin
          wbcnt_d = wbcnt_q - NW'(1);
          if (wbcnt_q == NW'(1)) state_d = msc_pkg::ST_SNRD;
        end
        msc_pkg::ST_REPL: begin
          state_d = (own_q[vway_q].coh == msc_pkg::COH_M) ? msc_pkg::ST_VWB
                                                         : msc_pkg::ST_WRITE;
        end
        msc_pkg::ST_VWB: begin
          state_d = msc_pkg::ST_WRITE;
        end
        msc_pkg::ST_WRITE: begin
          stamp_d = nst;
          state_d = msc_pkg::ST_DONE;
        end
        msc_pkg::ST_DONE: begin
          pend_v_d = 1'b0;
          evcnt_d  = '0;
          state_d  = msc_pkg::ST_IDLE;
        end
        default: state_d = msc_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mesi_snoop_cache_controller.sv =====
// Flow: a hit without bus traffic goes from the request queue through LOOK, WRITE and DONE;
// a miss or upgrade adds the BUS step, a snoop read and update of each other core's row, any
// write-backs and the replace steps (up to 7 events); a full event queue stalls the sequence.
// One request at a time in the back part; the next is taken only after DONE.
// Requests queue in a 2-entry buffer and events drain through a 2-entry output queue.
// Reset: all control clears; a clearing pass over all CORE_COUNT << SET_INDEX_BITS rows then
// marks every line invalid, and no request is taken until it ends.
module mesi_snoop_cache_controller #(
  parameter int unsigned CORE_COUNT     = 4,
  parameter int unsigned SET_INDEX_BITS = 6,
  parameter int unsigned WAY_COUNT      = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output msc_pkg::evt_t out_evt_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [4:0]    bo_q;
  logic [4:0]    offset;
  logic          q_ready, q_push, q_valid, q_pop;
  msc_pkg::cmd_t q_cmd_in, q_cmd_out;
  logic          ev_ready, ev_push;
  msc_pkg::evt_t ev;

  assign pready = 1'b1;
  assign prdata = 32'(bo_q);
  assign offset = (bo_q == 5'd0) ? 5'd1 : bo_q;

  // one register; every address decodes to it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bo_q <= 5'd6;
    end else if (psel && penable && pwrite && (paddr[1:0] <= 2'd3)) begin
      bo_q <= pwdata[4:0];
    end
  end

  msc_front #(
    .CORE_COUNT    (CORE_COUNT),
    .SET_INDEX_BITS(SET_INDEX_BITS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_req_i  (in_req_i),
    .offset_i  (offset),
    .q_ready_i (q_ready),
    .in_ready_o(in_ready_o),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in)
  );

  msc_fifo #(
    .WIDTH($bits(msc_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_cmd_in),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .data_o (q_cmd_out),
    .valid_o(q_valid)
  );

  msc_back #(
    .CORE_COUNT    (CORE_COUNT),
    .SET_INDEX_BITS(SET_INDEX_BITS),
    .WAY_COUNT     (WAY_COUNT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .offset_i  (offset),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd_out),
    .q_pop_o   (q_pop),
    .ev_ready_i(ev_ready),
    .ev_push_o (ev_push),
    .ev_o      (ev)
  );

  msc_fifo #(
    .WIDTH($bits(msc_pkg::evt_t))
  ) u_evt_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ev_push),
    .data_i (ev),
    .ready_o(ev_ready),
    .pop_i  (out_ready_i),
    .data_o (out_evt_o),
    .valid_o(out_valid_o)
  );

endmodule
